### rtl/itp_pkg.sv
`default_nettype none

package itp_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int BYTE_W      = 8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Operator codes as kept on the stack
  typedef enum logic [2:0] {
    CODE_NONE  = 3'd0,
    CODE_LPAR  = 3'd1,
    CODE_PLUS  = 3'd2,
    CODE_MINUS = 3'd3,
    CODE_MUL   = 3'd4,
    CODE_DIV   = 3'd5,
    CODE_POW   = 3'd6
  } op_code_t;

  // Expression characters
  localparam byte_t CHAR_NUL   = 8'h00;
  localparam byte_t CHAR_SPACE = 8'h20;
  localparam byte_t CHAR_LPAR  = 8'h28;
  localparam byte_t CHAR_RPAR  = 8'h29;
  localparam byte_t CHAR_MUL   = 8'h2A;
  localparam byte_t CHAR_PLUS  = 8'h2B;
  localparam byte_t CHAR_MINUS = 8'h2D;
  localparam byte_t CHAR_DIV   = 8'h2F;
  localparam byte_t CHAR_POW   = 8'h5E;

  // Stack request from the sequencer
  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stk_ctrl_t;

  // Stack status back to the sequencer
  typedef struct packed {
    cnt_t     count;
    op_code_t top;
  } stk_stat_t;

  function automatic op_code_t op_code(input byte_t c);
    case (c)
      CHAR_PLUS:  return CODE_PLUS;
      CHAR_MINUS: return CODE_MINUS;
      CHAR_MUL:   return CODE_MUL;
      CHAR_DIV:   return CODE_DIV;
      CHAR_POW:   return CODE_POW;
      default:    return CODE_NONE;
    endcase
  endfunction

  function automatic byte_t code_char(input op_code_t c);
    case (c)
      CODE_LPAR:  return CHAR_LPAR;
      CODE_PLUS:  return CHAR_PLUS;
      CODE_MINUS: return CHAR_MINUS;
      CODE_MUL:   return CHAR_MUL;
      CODE_DIV:   return CHAR_DIV;
      CODE_POW:   return CHAR_POW;
      default:    return CHAR_NUL;
    endcase
  endfunction

  function automatic logic [1:0] code_prec(input op_code_t c);
    case (c)
      CODE_PLUS, CODE_MINUS: return 2'd1;
      CODE_MUL, CODE_DIV:    return 2'd2;
      CODE_POW:              return 2'd3;
      default:               return 2'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/itp_stack.sv
`default_nettype none

module itp_stack (
  input  logic             clk,
  input  logic             rst,
  input  itp_pkg::stk_ctrl_t ctrl,
  output itp_pkg::stk_stat_t stat
);
  import itp_pkg::*;

  op_code_t          mem [STACK_DEPTH];
  cnt_t              count;
  op_code_t          top;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Write above the top, read the top entry
  assign wr_addr = count[ADDR_W-1:0];
  assign rd_addr = (count == '0) ? '0 : ADDR_W'(count - 1'b1);

  // Track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push && !ctrl.pop) begin
      count <= count + 1'b1;
    end else if (ctrl.pop && !ctrl.push) begin
      count <= count - 1'b1;
    end
  end

  // Write on push, register the top entry every cycle
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_addr] <= ctrl.code;
    end
    top <= mem[rd_addr];
  end

  assign stat = '{count: count, top: top};

endmodule

`default_nettype wire

### rtl/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting-yard).
// Input stream: one expression byte per request in s_tdata, s_tlast set on
// the final byte of an expression. Output stream: postfix bytes in m_tdata,
// m_tlast on the last result caused by an input byte, m_tuser flags for the
// expression terminator (a zero byte) and a sticky stack-overflow mark.
// Each input byte runs through a small sequencer that drives one operator
// stack; s_tready is high only while the sequencer waits for a byte.
// Steps per byte: decode (which pushes a '(' or an operator onto an empty
// stack and passes an operand on); then per stack entry a top read and a
// compare that pops it or, for an operator, stops the pops; a push step for
// an operator on a non-empty stack; end; for an end-of-expression the same
// read and compare per entry to flush the stack and a terminator; finish.
// An operand's result enters the hold stage at decode.
// A one-entry hold stage keeps the latest result until the sequencer knows
// whether it is the last of the run; the output register then waits for
// m_tready. While the receiver stalls the sequencer stops at its next result.
// Reset empties the stack and the output stage and clears the overflow mark.
// A push onto a full stack is dropped and raises the overflow mark up to
// and including the terminator of that expression.
`default_nettype none

module infix_to_postfix_converter (
  input  logic                 clk,
  input  logic                 rst,
  // s_tdata: [7:0] character
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  itp_pkg::byte_t       s_tdata,
  input  logic                 s_tlast,
  // m_tdata: [7:0] symbol
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output itp_pkg::byte_t       m_tdata,
  output logic                 m_tlast,
  // m_tuser: [0] expression_done, [1] stack_overflow
  output logic [1:0]           m_tuser
);
  import itp_pkg::*;

  localparam int TUSER_DONE = 0;
  localparam int TUSER_OVF  = 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CHECK,
    S_PUSH,
    S_END,
    S_TERM,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    M_RPAR,
    M_OP,
    M_FLUSH
  } mode_t;

  state_t    state;
  mode_t     mode;
  byte_t     ch;
  logic      eoe;
  op_code_t  oc;
  logic      ovf;
  logic      pend_valid;
  byte_t     pend_sym;
  logic      pend_done;
  logic      pend_ovf;

  stk_ctrl_t stk_ctrl;
  stk_stat_t stk_stat;

  logic      out_free;
  logic      out_load;
  logic      can_emit;
  logic      full;
  logic      is_blank;
  logic      is_lpar;
  logic      is_rpar;
  logic      is_op;
  logic      top_pops;
  logic      want_push;
  logic      want_pop;
  logic      emit_req;
  byte_t     emit_sym;
  logic      emit_done;
  logic      emit_fire;
  logic      last_pop;

  itp_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (stk_ctrl),
    .stat (stk_stat)
  );

  // Classify the held byte and the stack top
  assign out_free = !m_tvalid || m_tready;
  assign can_emit = !pend_valid || out_free;
  assign full     = stk_stat.count >= cnt_t'(STACK_DEPTH);
  assign is_blank = (ch == CHAR_SPACE) || (ch == CHAR_NUL);
  assign is_lpar  = ch == CHAR_LPAR;
  assign is_rpar  = ch == CHAR_RPAR;
  assign is_op    = oc != CODE_NONE;
  assign top_pops = (stk_stat.top != CODE_LPAR) &&
                    (code_prec(stk_stat.top) >= code_prec(oc));
  assign last_pop = stk_stat.count == cnt_t'(1);
  assign s_tready = state == S_IDLE;

  // Decide this cycle's stack action and result
  always_comb begin
    want_push = 1'b0;
    want_pop  = 1'b0;
    emit_req  = 1'b0;
    emit_sym  = ch;
    emit_done = 1'b0;
    case (state)
      S_DECODE: begin
        if (is_blank) begin
          want_push = 1'b0;
        end else if (is_lpar) begin
          want_push = 1'b1;
        end else if (is_op) begin
          want_push = stk_stat.count == '0;
        end else if (!is_rpar) begin
          emit_req = 1'b1;
        end
      end
      S_CHECK: begin
        case (mode)
          M_RPAR: begin
            want_pop = 1'b1;
            emit_req = stk_stat.top != CODE_LPAR;
          end
          M_OP: begin
            want_pop = top_pops;
            emit_req = top_pops;
          end
          default: begin
            want_pop = 1'b1;
            emit_req = 1'b1;
          end
        endcase
        emit_sym = code_char(stk_stat.top);
      end
      S_PUSH: begin
        want_push = 1'b1;
      end
      S_TERM: begin
        emit_req  = 1'b1;
        emit_sym  = CHAR_NUL;
        emit_done = 1'b1;
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  assign emit_fire = emit_req && can_emit;
  assign out_load  = pend_valid && out_free && (emit_req || state == S_FINISH);
  assign stk_ctrl  = '{push: want_push && !full,
                       pop:  want_pop && (!emit_req || can_emit),
                       code: is_lpar ? CODE_LPAR : oc};

  // Sequence one byte, hold the latest result, drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // Load the output register, or drop a result once it is taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Move the held result out, not last, when a new one arrives
      if (emit_fire) begin
        if (pend_valid) begin
          m_tdata             <= pend_sym;
          m_tlast             <= 1'b0;
          m_tuser[TUSER_DONE] <= pend_done;
          m_tuser[TUSER_OVF]  <= pend_ovf;
        end
        pend_valid <= 1'b1;
        pend_sym   <= emit_sym;
        pend_done  <= emit_done;
        pend_ovf   <= ovf;
      end

      // Mark a dropped push
      if (want_push && full) begin
        ovf <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ch    <= s_tdata;
            eoe   <= s_tlast;
            oc    <= op_code(s_tdata);
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if ((is_rpar || is_op) && stk_stat.count != '0) begin
            mode  <= is_rpar ? M_RPAR : M_OP;
            state <= S_READ;
          end else begin
            state <= S_END;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          case (mode)
            M_RPAR: begin
              if (stk_stat.top == CODE_LPAR) begin
                state <= S_END;
              end else if (can_emit) begin
                state <= last_pop ? S_END : S_READ;
              end
            end
            M_OP: begin
              if (!top_pops) begin
                state <= S_PUSH;
              end else if (can_emit) begin
                state <= last_pop ? S_PUSH : S_READ;
              end
            end
            default: begin
              if (can_emit) begin
                state <= last_pop ? S_TERM : S_READ;
              end
            end
          endcase
        end
        S_PUSH: begin
          state <= S_END;
        end
        S_END: begin
          if (!eoe) begin
            state <= S_FINISH;
          end else if (stk_stat.count != '0) begin
            mode  <= M_FLUSH;
            state <= S_READ;
          end else begin
            state <= S_TERM;
          end
        end
        S_TERM: begin
          if (can_emit) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Release the held result as the last of the run
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              m_tdata             <= pend_sym;
              m_tlast             <= 1'b1;
              m_tuser[TUSER_DONE] <= pend_done;
              m_tuser[TUSER_OVF]  <= pend_ovf;
              pend_valid          <= 1'b0;
            end
            if (eoe) begin
              ovf <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stk_stat.count <= cnt_t'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    stk_ctrl.pop |-> stk_stat.count != '0)
    else $error("pop from an empty operator stack");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[TUSER_DONE] |-> m_tlast && m_tdata == CHAR_NUL)
    else $error("terminator not marked last of run");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("held result left over at byte accept");
`endif

endmodule

`default_nettype wire

### sim/tb_infix_to_postfix_converter.sv
`default_nettype none

module tb_infix_to_postfix_converter;
  import itp_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 350;
  localparam int DIR_ROWS    = 25;
  localparam int PREDICT     = -1;
  localparam int RUN_MAX     = STACK_DEPTH + 8;

  // Flag tails of a typed symbol: {last_of_run, expr_done, ovf}
  localparam logic [2:0] MID_RUN  = 3'b000;
  localparam logic [2:0] RUN_END  = 3'b100;
  localparam logic [2:0] EXPR_END = 3'b110;

  // Glyph and precedence per stack code, indexed by op_code_t
  localparam logic [0:7][7:0] OP_GLYPH = {CHAR_NUL, CHAR_LPAR, CHAR_PLUS, CHAR_MINUS,
                                          CHAR_MUL, CHAR_DIV, CHAR_POW, CHAR_NUL};
  localparam logic [0:7][1:0] OP_RANK  = {2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0};

  typedef struct packed {
    byte_t symbol;
    logic  last_of_run;
    logic  expr_done;
    logic  ovf;
  } postfix_sym_t;

  typedef struct packed {
    byte_t        ch;
    logic         eoe;
    int           n_exp;
    postfix_sym_t e0;
    postfix_sym_t e1;
  } dir_row_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  byte_t      s_tdata  = CHAR_NUL;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  byte_t      m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  // Predictor state
  op_code_t     op_stack [STACK_DEPTH];
  int           op_depth   = 0;
  bit           ovf_sticky = 1'b0;
  postfix_sym_t run_buf [RUN_MAX];
  int           run_n;

  // Expected symbols, oldest first
  postfix_sym_t postfix_q [$];
  byte_t        expr_q [$];
  dir_row_t     dir_tab [DIR_ROWS];

  int           typed_n = PREDICT;
  postfix_sym_t typed_e0, typed_e1;

  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  int err_cnt   = 0;
  int item_cnt  = 0;
  int expr_cnt  = 0;
  int sym_cnt   = 0;
  int ovf_cnt   = 0;
  int cycle_cnt = 0;

  infix_to_postfix_converter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** infix_to_postfix_converter: FAILED **");
      $finish;
    end
  end

  function automatic void emit_sym(input byte_t sym, input logic done);
    run_buf[run_n] = {sym, 1'b0, done, 1'b0};
    run_n++;
  endfunction

  function automatic void pop_to_output();
    emit_sym(OP_GLYPH[op_stack[op_depth-1]], 1'b0);
    op_depth--;
  endfunction

  function automatic void push_op(input op_code_t code);
    if (op_depth >= STACK_DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      op_stack[op_depth] = code;
      op_depth++;
    end
  endfunction

  // Shunting-yard step: fill run_buf with the symbols one character causes
  function automatic void convert_char(input byte_t ch, input logic eoe);
    op_code_t code;
    run_n = 0;
    case (ch)
      CHAR_PLUS:  code = CODE_PLUS;
      CHAR_MINUS: code = CODE_MINUS;
      CHAR_MUL:   code = CODE_MUL;
      CHAR_DIV:   code = CODE_DIV;
      CHAR_POW:   code = CODE_POW;
      default:    code = CODE_NONE;
    endcase
    if (ch == CHAR_SPACE || ch == CHAR_NUL) begin
      // ignored
    end else if (ch == CHAR_LPAR) begin
      push_op(CODE_LPAR);
    end else if (ch == CHAR_RPAR) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CODE_LPAR)
        pop_to_output();
      if (op_depth > 0)
        op_depth--;
    end else if (code != CODE_NONE) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CODE_LPAR &&
             OP_RANK[op_stack[op_depth-1]] >= OP_RANK[code])
        pop_to_output();
      push_op(code);
    end else begin
      emit_sym(ch, 1'b0);
    end
    // Flush the stack and close the expression
    if (eoe) begin
      while (op_depth > 0)
        pop_to_output();
      emit_sym(CHAR_NUL, 1'b1);
    end
    for (int k = 0; k < run_n; k++)
      run_buf[k].ovf = ovf_sticky;
    if (run_n > 0)
      run_buf[run_n-1].last_of_run = 1'b1;
    if (eoe) begin
      op_depth   = 0;
      ovf_sticky = 1'b0;
      expr_cnt++;
    end
  endfunction

  // Drive one request, hold it until accepted, then queue its symbols
  task automatic send_req(input byte_t ch, input logic eoe);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eoe;
    do @(posedge clk); while (s_tready !== 1'b1);
    convert_char(ch, eoe);
    if (typed_n == PREDICT) begin
      for (int k = 0; k < run_n; k++)
        postfix_q.push_back(run_buf[k]);
    end else begin
      if (typed_n > 0) postfix_q.push_back(typed_e0);
      if (typed_n > 1) postfix_q.push_back(typed_e1);
    end
    if (ch != CHAR_SPACE && ch != CHAR_NUL)
      item_cnt++;
    gap = quiet_tx ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every queued symbol has come out
  task automatic drain_wait();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (postfix_q.size() != 0);
  endtask

  task automatic send_expr();
    foreach (expr_q[i])
      send_req(expr_q[i], i == expr_q.size() - 1);
    expr_q.delete();
  endtask

  function automatic byte_t pick_operand();
    byte_t c;
    if ($urandom_range(0, 3) != 0)
      return byte_t'($urandom_range(8'h61, 8'h7A));
    do begin
      c = byte_t'($urandom_range(0, 255));
    end while (c == CHAR_NUL || c == CHAR_SPACE || c == CHAR_LPAR || c == CHAR_RPAR ||
               c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_MUL || c == CHAR_DIV ||
               c == CHAR_POW);
    return c;
  endfunction

  function automatic byte_t pick_operator();
    case ($urandom_range(0, 4))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_MUL;
      3:       return CHAR_DIV;
      default: return CHAR_POW;
    endcase
  endfunction

  // Well-formed expression, parentheses mostly balanced
  task automatic build_formula();
    int terms;
    int open;
    terms = $urandom_range(1, 10);
    open  = 0;
    for (int k = 0; k < terms; k++) begin
      while (open < 6 && $urandom_range(0, 3) == 0) begin
        expr_q.push_back(CHAR_LPAR);
        open++;
      end
      expr_q.push_back(pick_operand());
      if ($urandom_range(0, 5) == 0)
        expr_q.push_back(CHAR_SPACE);
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(CHAR_RPAR);
        open--;
      end
      if (k != terms - 1)
        expr_q.push_back(pick_operator());
    end
    // Leave some groups open for the flush
    if ($urandom_range(0, 4) != 0)
      repeat (open) expr_q.push_back(CHAR_RPAR);
    if ($urandom_range(0, 7) == 0)
      expr_q.push_back(CHAR_SPACE);
  endtask

  // Deep nesting to fill the stack
  task automatic build_nest(input int levels);
    repeat (levels) begin
      if ($urandom_range(0, 2) == 0) begin
        expr_q.push_back(pick_operand());
        expr_q.push_back(pick_operator());
      end
      expr_q.push_back(CHAR_LPAR);
    end
    expr_q.push_back(pick_operand());
    repeat ($urandom_range(0, levels)) expr_q.push_back(CHAR_RPAR);
  endtask

  // Broken sequences and arbitrary bytes
  task automatic build_noise();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0: expr_q.push_back(byte_t'($urandom_range(0, 255)));
        1: expr_q.push_back(pick_operator());
        2: expr_q.push_back($urandom_range(0, 1) ? CHAR_LPAR : CHAR_RPAR);
        default: expr_q.push_back(pick_operand());
      endcase
    end
  endtask

  function automatic dir_row_t row(input byte_t ch, input logic eoe, input int n_exp,
                                   input postfix_sym_t e0 = '0,
                                   input postfix_sym_t e1 = '0);
    return '{ch: ch, eoe: eoe, n_exp: n_exp, e0: e0, e1: e1};
  endfunction

  // Receiver: random stall per result, check against the oldest expectation
  initial begin : rx_side
    int stall;
    postfix_sym_t want;
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sym_cnt++;
      if (m_tuser[1] === 1'b1)
        ovf_cnt++;
      if (postfix_q.size() == 0) begin
        $error("unexpected symbol: got %h", m_tdata);
        err_cnt++;
      end else begin
        want = postfix_q.pop_front();
        if (m_tdata !== want.symbol) begin
          $error("symbol: expected %h, got %h", want.symbol, m_tdata);
          err_cnt++;
        end
        if (m_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, m_tlast);
          err_cnt++;
        end
        if (m_tuser[0] !== want.expr_done) begin
          $error("expression_done: expected %b, got %b", want.expr_done, m_tuser[0]);
          err_cnt++;
        end
        if (m_tuser[1] !== want.ovf) begin
          $error("stack_overflow: expected %b, got %b", want.ovf, m_tuser[1]);
          err_cnt++;
        end
      end
      if (sym_cnt % 25 == 0)
        quiet_rx = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : tx_side
    // Operands and edge bytes, ignored bytes, every operator, stray and open groups
    dir_tab[0]  = row("a",        1'b0, 1, {8'h61, RUN_END});
    dir_tab[1]  = row(8'hFF,      1'b0, 1, {8'hFF, RUN_END});
    dir_tab[2]  = row(8'h01,      1'b0, 1, {8'h01, RUN_END});
    dir_tab[3]  = row(CHAR_SPACE, 1'b0, 0);
    dir_tab[4]  = row(CHAR_NUL,   1'b1, 1, {CHAR_NUL, EXPR_END});
    dir_tab[5]  = row(CHAR_LPAR,  1'b0, PREDICT);
    dir_tab[6]  = row("a",        1'b0, PREDICT);
    dir_tab[7]  = row(CHAR_PLUS,  1'b0, PREDICT);
    dir_tab[8]  = row("b",        1'b0, PREDICT);
    dir_tab[9]  = row(CHAR_RPAR,  1'b0, PREDICT);
    dir_tab[10] = row(CHAR_MUL,   1'b0, PREDICT);
    dir_tab[11] = row("c",        1'b0, PREDICT);
    dir_tab[12] = row(CHAR_MINUS, 1'b0, PREDICT);
    dir_tab[13] = row("d",        1'b0, PREDICT);
    dir_tab[14] = row(CHAR_DIV,   1'b0, PREDICT);
    dir_tab[15] = row("e",        1'b0, PREDICT);
    dir_tab[16] = row(CHAR_POW,   1'b0, PREDICT);
    dir_tab[17] = row("f",        1'b0, PREDICT);
    dir_tab[18] = row(CHAR_POW,   1'b0, PREDICT);
    dir_tab[19] = row("g",        1'b1, PREDICT);
    dir_tab[20] = row(CHAR_RPAR,  1'b0, 0);
    dir_tab[21] = row(CHAR_LPAR,  1'b0, PREDICT);
    dir_tab[22] = row("x",        1'b0, PREDICT);
    dir_tab[23] = row(CHAR_SPACE, 1'b1, 2, {CHAR_LPAR, MID_RUN}, {CHAR_NUL, EXPR_END});
    dir_tab[24] = row(CHAR_PLUS,  1'b1, 2, {CHAR_PLUS, MID_RUN}, {CHAR_NUL, EXPR_END});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_n  = dir_tab[i].n_exp;
      typed_e0 = dir_tab[i].e0;
      typed_e1 = dir_tab[i].e1;
      send_req(dir_tab[i].ch, dir_tab[i].eoe);
    end
    typed_n = PREDICT;
    drain_wait();

    // Overflow first, then a random mix
    build_nest(36);
    send_expr();
    while (item_cnt < ITEM_TARGET) begin
      quiet_tx = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0)
        drain_wait();
      case ($urandom_range(0, 9))
        0:       build_nest($urandom_range(20, 40));
        1, 2:    build_noise();
        default: build_formula();
      endcase
      send_expr();
    end

    drain_wait();
    repeat (40) @(posedge clk);

    $display("Converted %0d expressions (%0d non-blank characters) into %0d postfix symbols,",
             expr_cnt, item_cnt, sym_cnt);
    $display("%0d of them under a stack overflow, with random stalls on both streams.",
             ovf_cnt);
    if (err_cnt == 0) begin
      $display("** infix_to_postfix_converter: PASSED **");
    end else begin
      $display("** infix_to_postfix_converter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
